[design/pmc_pkg.sv]
// Shared constants and widths for the Prim maze carver.
package pmc_pkg;

  localparam int unsigned DEF_MAX_ROWS = 32;
  localparam int unsigned DEF_MAX_COLS = 32;

  localparam int unsigned KIND_W  = 1;
  localparam int unsigned RAND_W  = 32;
  localparam int unsigned COORD_W = 5;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned FLAG_W  = 6;

  localparam int unsigned FLAG_IN_BIT    = 4;
  localparam int unsigned FLAG_FRONT_BIT = 5;

  localparam logic [KIND_W-1:0] KIND_START = 1'b0;
  localparam logic [KIND_W-1:0] KIND_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic [CFG_W-1:0] RESET_ROWS = 6'd16;
  localparam logic [CFG_W-1:0] RESET_COLS = 6'd16;

endpackage

[design/pmc_in_if.sv]
// Input channel of the maze carver: one start or step item.
interface pmc_in_if;
  logic                         valid;
  logic                         ready;
  logic [pmc_pkg::KIND_W-1:0]   kind;
  logic [pmc_pkg::RAND_W-1:0]   first_random;
  logic [pmc_pkg::RAND_W-1:0]   second_random;

  modport source (output valid, kind, first_random, second_random, input ready);
  modport sink   (input valid, kind, first_random, second_random, output ready);
endinterface

[design/pmc_out_if.sv]
// Output channel of the maze carver: one result item per input item.
interface pmc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pmc_pkg::COORD_W-1:0]   cell_row;
  logic [pmc_pkg::COORD_W-1:0]   cell_col;
  logic [pmc_pkg::COORD_W-1:0]   link_row;
  logic [pmc_pkg::COORD_W-1:0]   link_col;
  logic [pmc_pkg::DIR_W-1:0]     link_dir;
  logic                          carved;
  logic                          done_res;

  modport source (output valid, cell_row, cell_col, link_row, link_col, link_dir, carved,
                  done_res, input ready);
  modport sink   (input valid, cell_row, cell_col, link_row, link_col, link_dir, carved,
                  done_res, output ready);
endinterface

[design/pmc_ram.sv]
// Generic simple dual-port RAM with registered read.
module pmc_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/pmc_div.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module pmc_div #(
  parameter int unsigned DW = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pmc_pkg::RAND_W-1:0] dividend_i,
  input  logic [DW-1:0]              divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [DW-1:0]              rem_o
);

  localparam int unsigned CNT_W = $clog2(pmc_pkg::RAND_W);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [DW-1:0]              rem_q, rem_d;
  logic [DW-1:0]              dsr_q, dsr_d;
  logic [pmc_pkg::RAND_W-1:0] dvd_q, dvd_d;
  logic [DW:0]                trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    trial  = {rem_q, dvd_q[pmc_pkg::RAND_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = DW'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[DW-1:0];
      end
      dvd_d = {dvd_q[pmc_pkg::RAND_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(pmc_pkg::RAND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      dvd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      dsr_q  <= dsr_d;
      dvd_q  <= dvd_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[design/prim_maze_carver.sv]
// Randomized Prim maze carver: cell flags and frontier list in RAM, one item at a time.
// Start item: accept, clear all cell flags, row and column remainders, write-back, result.
// Step item with an empty frontier: accept, result.
// Step item: accept, pick remainder, list read, shift of the entries after the pick,
//   flag read and select, remainder when carving, write-back, result.
// Next item accepted once the result is loaded. Reset clears the count, grid regs to 16.
module prim_maze_carver #(
  parameter int unsigned MAX_ROWS = pmc_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = pmc_pkg::DEF_MAX_COLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pmc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pmc_pkg::CFG_W-1:0]     cfg_data_i,
  pmc_in_if.sink                        in_i,
  pmc_out_if.source                     out_o
);

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned CW    = $clog2(CELLS);
  localparam int unsigned CNTW  = $clog2(CELLS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CLW   = $clog2(MAX_COLS);
  localparam int unsigned FEW   = RW + CLW;
  localparam int unsigned FW    = pmc_pkg::FLAG_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_DIVR  = 4'd2;
  localparam logic [3:0] S_DIVC  = 4'd3;
  localparam logic [3:0] S_DIVP  = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FWAIT = 4'd6;
  localparam logic [3:0] S_SHIFT = 4'd7;
  localparam logic [3:0] S_FLRD  = 4'd8;
  localparam logic [3:0] S_SEL   = 4'd9;
  localparam logic [3:0] S_DIVN  = 4'd10;
  localparam logic [3:0] S_WB    = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]                 state_q, state_d;
  logic [pmc_pkg::CFG_W-1:0]  rows_q, cols_q;
  logic [pmc_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [pmc_pkg::RAND_W-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [RW-1:0]              r_q, r_d;
  logic [CLW-1:0]             c_q, c_d;
  logic [CNTW-1:0]            pick_q, pick_d, rd_ptr_q, rd_ptr_d, count_q, count_d;
  logic [CW-1:0]              wr_ptr_q, wr_ptr_d, clr_ptr_q, clr_ptr_d;
  logic                       pend_q, pend_d;
  logic [2:0]                 fk_q, fk_d, wk_q, wk_d;
  logic [FW-1:0]              fl_q [5];
  logic [FW-1:0]              fl_d [5];
  logic                       carved_q, carved_d, done_q, done_d;
  logic [1:0]                 dir_q, dir_d;

  logic                          out_valid_q, out_valid_d;
  logic [pmc_pkg::COORD_W-1:0]   o_cr_q, o_cc_q, o_lr_q, o_lc_q;
  logic [pmc_pkg::COORD_W-1:0]   o_cr_d, o_cc_d, o_lr_d, o_lc_d;
  logic [pmc_pkg::DIR_W-1:0]     o_dir_q, o_dir_d;
  logic                          o_car_q, o_car_d, o_done_q, o_done_d;

  logic [CNTW-1:0] rows_u, cols_u;
  logic [RW-1:0]   nb_r [4];
  logic [CLW-1:0]  nb_c [4];
  logic [CW-1:0]   slot_addr [5];
  logic [3:0]      nv, im;
  logic [2:0]      n_in;
  logic [1:0]      sel_dir;
  logic [2:0]      sel_cnt;
  logic [FW-1:0]   self_new;
  logic [FW-1:0]   nb_new [4];
  logic            rd_issue;

  logic                       fl_we, fr_we;
  logic [CW-1:0]              fl_waddr, fl_raddr, fr_waddr, fr_raddr;
  logic [FW-1:0]              fl_wdata, fl_rdata;
  logic [FEW-1:0]             fr_wdata, fr_rdata;

  logic                       div_start, div_busy, div_done;
  logic [pmc_pkg::RAND_W-1:0] div_dvd;
  logic [CNTW-1:0]            div_dsr, div_rem;

  pmc_ram #(.W(FW), .D(CELLS)) u_flags (
    .clk_i, .we_i(fl_we), .waddr_i(fl_waddr), .wdata_i(fl_wdata),
    .raddr_i(fl_raddr), .rdata_o(fl_rdata)
  );

  pmc_ram #(.W(FEW), .D(CELLS)) u_front (
    .clk_i, .we_i(fr_we), .waddr_i(fr_waddr), .wdata_i(fr_wdata),
    .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );

  pmc_div #(.DW(CNTW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd), .divisor_i(div_dsr),
    .busy_o(div_busy), .done_o(div_done), .rem_o(div_rem)
  );

  always_comb begin
    if (rows_q == '0) begin
      rows_u = CNTW'(1);
    end else if (int'(rows_q) > int'(MAX_ROWS)) begin
      rows_u = CNTW'(MAX_ROWS);
    end else begin
      rows_u = CNTW'(int'(rows_q));
    end
    if (cols_q == '0) begin
      cols_u = CNTW'(1);
    end else if (int'(cols_q) > int'(MAX_COLS)) begin
      cols_u = CNTW'(MAX_COLS);
    end else begin
      cols_u = CNTW'(int'(cols_q));
    end
  end

  always_comb begin
    nb_r[0] = r_q - 1'b1;  nb_c[0] = c_q;
    nb_r[1] = r_q + 1'b1;  nb_c[1] = c_q;
    nb_r[2] = r_q;         nb_c[2] = c_q - 1'b1;
    nb_r[3] = r_q;         nb_c[3] = c_q + 1'b1;
    nv[0] = (r_q != '0) && (int'(r_q) - 1 < int'(rows_u)) && (int'(c_q) < int'(cols_u));
    nv[1] = (int'(r_q) + 1 < int'(rows_u)) && (int'(c_q) < int'(cols_u));
    nv[2] = (c_q != '0) && (int'(r_q) < int'(rows_u)) && (int'(c_q) - 1 < int'(cols_u));
    nv[3] = (int'(c_q) + 1 < int'(cols_u)) && (int'(r_q) < int'(rows_u));
    slot_addr[0] = CW'(r_q) * CW'(MAX_COLS) + CW'(c_q);
    for (int d = 0; d < 4; d++) begin
      slot_addr[d+1] = nv[d] ? CW'(nb_r[d]) * CW'(MAX_COLS) + CW'(nb_c[d]) : slot_addr[0];
      im[d] = nv[d] && fl_q[d+1][pmc_pkg::FLAG_IN_BIT];
    end
    n_in = 3'(im[0]) + 3'(im[1]) + 3'(im[2]) + 3'(im[3]);
    sel_dir = 2'd0;
    sel_cnt = 3'd0;
    for (int d = 0; d < 4; d++) begin
      if (im[d]) begin
        if (sel_cnt == {1'b0, div_rem[1:0]}) begin
          sel_dir = 2'(d);
        end
        sel_cnt = sel_cnt + 3'd1;
      end
    end
    self_new = fl_q[0];
    self_new[pmc_pkg::FLAG_IN_BIT] = 1'b1;
    if (kind_q == pmc_pkg::KIND_START) begin
      self_new[pmc_pkg::FLAG_FRONT_BIT] = 1'b1;
    end
    if (carved_q) begin
      self_new[dir_q] = 1'b1;
    end
    for (int d = 0; d < 4; d++) begin
      nb_new[d] = fl_q[d+1];
      nb_new[d][pmc_pkg::FLAG_FRONT_BIT] = 1'b1;
      if (carved_q && dir_q == 2'(d)) begin
        nb_new[d][d ^ 1] = 1'b1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    r_d       = r_q;
    c_d       = c_q;
    pick_d    = pick_q;
    rd_ptr_d  = rd_ptr_q;
    count_d   = count_q;
    wr_ptr_d  = wr_ptr_q;
    clr_ptr_d = clr_ptr_q;
    pend_d    = pend_q;
    fk_d      = fk_q;
    wk_d      = wk_q;
    fl_d      = fl_q;
    carved_d  = carved_q;
    done_d    = done_q;
    dir_d     = dir_q;
    o_cr_d    = o_cr_q;
    o_cc_d    = o_cc_q;
    o_lr_d    = o_lr_q;
    o_lc_d    = o_lc_q;
    o_dir_d   = o_dir_q;
    o_car_d   = o_car_q;
    o_done_d  = o_done_q;
    out_valid_d = out_valid_q && !out_o.ready;
    fl_we     = 1'b0;
    fl_waddr  = slot_addr[0];
    fl_wdata  = self_new;
    fl_raddr  = slot_addr[0];
    fr_we     = 1'b0;
    fr_waddr  = wr_ptr_q;
    fr_wdata  = fr_rdata;
    fr_raddr  = pick_q[CW-1:0];
    rd_issue  = 1'b0;
    div_start = 1'b0;
    div_dvd   = ra_q;
    div_dsr   = count_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d   = in_i.kind;
          ra_d     = in_i.first_random;
          rb_d     = in_i.second_random;
          carved_d = 1'b0;
          done_d   = 1'b0;
          dir_d    = 2'd0;
          if (in_i.kind == pmc_pkg::KIND_START) begin
            clr_ptr_d = '0;
            state_d   = S_CLR;
          end else if (count_q == '0) begin
            done_d  = 1'b1;
            r_d     = '0;
            c_d     = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_DIVP;
          end
        end
      end
      S_CLR: begin
        fl_we    = 1'b1;
        fl_waddr = clr_ptr_q;
        fl_wdata = '0;
        if (clr_ptr_q == CW'(CELLS - 1)) begin
          count_d = '0;
          state_d = S_DIVR;
        end else begin
          clr_ptr_d = clr_ptr_q + 1'b1;
        end
      end
      S_DIVR: begin
        div_dsr   = rows_u;
        div_start = !div_busy && !div_done;
        if (div_done) begin
          r_d     = RW'(div_rem);
          state_d = S_DIVC;
        end
      end
      S_DIVC: begin
        div_dvd   = rb_q;
        div_dsr   = cols_u;
        div_start = !div_busy && !div_done;
        if (div_done) begin
          c_d = CLW'(div_rem);
          for (int k = 0; k < 5; k++) begin
            fl_d[k] = '0;
          end
          wk_d    = '0;
          state_d = S_WB;
        end
      end
      S_DIVP: begin
        div_start = !div_busy && !div_done;
        if (div_done) begin
          pick_d  = div_rem;
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        state_d = S_FWAIT;
      end
      S_FWAIT: begin
        r_d      = fr_rdata[FEW-1:CLW];
        c_d      = fr_rdata[CLW-1:0];
        rd_ptr_d = pick_q + 1'b1;
        wr_ptr_d = pick_q[CW-1:0];
        pend_d   = 1'b0;
        state_d  = S_SHIFT;
      end
      S_SHIFT: begin
        rd_issue = rd_ptr_q < count_q;
        if (rd_issue) begin
          fr_raddr = rd_ptr_q[CW-1:0];
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
        if (pend_q) begin
          fr_we    = 1'b1;
          wr_ptr_d = wr_ptr_q + 1'b1;
        end
        pend_d = rd_issue;
        if (!rd_issue && !pend_q) begin
          count_d = count_q - 1'b1;
          fk_d    = '0;
          state_d = S_FLRD;
        end
      end
      S_FLRD: begin
        if (fk_q < 3'd5) begin
          fl_raddr = slot_addr[fk_q];
        end
        if (fk_q != '0) begin
          fl_d[fk_q - 3'd1] = fl_rdata;
        end
        fk_d = fk_q + 3'd1;
        if (fk_q == 3'd5) begin
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        wk_d    = '0;
        state_d = (n_in == '0) ? S_WB : S_DIVN;
      end
      S_DIVN: begin
        div_dvd   = rb_q;
        div_dsr   = CNTW'(n_in);
        div_start = !div_busy && !div_done;
        if (div_done) begin
          carved_d = 1'b1;
          dir_d    = sel_dir;
          state_d  = S_WB;
        end
      end
      S_WB: begin
        if (wk_q == '0) begin
          fl_we = 1'b1;
        end else begin
          fl_waddr = slot_addr[wk_q];
          fl_wdata = nb_new[2'(wk_q - 3'd1)];
          if (nv[2'(wk_q - 3'd1)]) begin
            fl_we = 1'b1;
            if (!fl_q[wk_q][pmc_pkg::FLAG_FRONT_BIT] && count_q < CNTW'(CELLS)) begin
              fr_we    = 1'b1;
              fr_waddr = count_q[CW-1:0];
              fr_wdata = {nb_r[2'(wk_q - 3'd1)], nb_c[2'(wk_q - 3'd1)]};
              count_d  = count_q + 1'b1;
            end
          end
        end
        wk_d = wk_q + 3'd1;
        if (wk_q == 3'd4) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          o_cr_d   = pmc_pkg::COORD_W'(r_q);
          o_cc_d   = pmc_pkg::COORD_W'(c_q);
          o_lr_d   = carved_q ? pmc_pkg::COORD_W'(nb_r[dir_q]) : '0;
          o_lc_d   = carved_q ? pmc_pkg::COORD_W'(nb_c[dir_q]) : '0;
          o_dir_d  = carved_q ? dir_q : '0;
          o_car_d  = carved_q;
          o_done_d = done_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_q      <= pmc_pkg::RESET_ROWS;
      cols_q      <= pmc_pkg::RESET_COLS;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      fk_q        <= '0;
      wk_q        <= '0;
      clr_ptr_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      fk_q        <= fk_d;
      wk_q        <= wk_d;
      clr_ptr_q   <= clr_ptr_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pmc_pkg::REG_GRID_ROWS: rows_q <= cfg_data_i;
          pmc_pkg::REG_GRID_COLS: cols_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    ra_q     <= ra_d;
    rb_q     <= rb_d;
    r_q      <= r_d;
    c_q      <= c_d;
    pick_q   <= pick_d;
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    fl_q     <= fl_d;
    carved_q <= carved_d;
    done_q   <= done_d;
    dir_q    <= dir_d;
    o_cr_q   <= o_cr_d;
    o_cc_q   <= o_cc_d;
    o_lr_q   <= o_lr_d;
    o_lc_q   <= o_lc_d;
    o_dir_q  <= o_dir_d;
    o_car_q  <= o_car_d;
    o_done_q <= o_done_d;
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.cell_row = o_cr_q;
  assign out_o.cell_col = o_cc_q;
  assign out_o.link_row = o_lr_q;
  assign out_o.link_col = o_lc_q;
  assign out_o.link_dir = o_dir_q;
  assign out_o.carved   = o_car_q;
  assign out_o.done_res = o_done_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CELLS))
    else $error("frontier count beyond capacity");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVR || state_q == S_DIVC || state_q == S_DIVP ||
                  state_q == S_DIVN))
    else $error("remainder finished outside a remainder state");

  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> count_q != '0)
    else $error("frontier shift with empty list");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q)
    else $error("result dropped before it was taken");

  a_carve_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && carved_q |-> kind_q == pmc_pkg::KIND_STEP && !done_q)
    else $error("passage reported on a start or done item");

endmodule

[tb/sv/tb_prim_maze_carver.sv]
// Self-checking testbench for the Prim maze carver: random start and step items, scoreboard.
`timescale 1ns / 1ps

module tb_prim_maze_carver;

  localparam int unsigned NROW   = pmc_pkg::DEF_MAX_ROWS;
  localparam int unsigned NCOL   = pmc_pkg::DEF_MAX_COLS;
  localparam int unsigned NCELL  = NROW * NCOL;
  localparam int unsigned LIMIT  = 4000000;
  localparam int unsigned HOLD_N = 3000;

  typedef struct packed {
    logic [pmc_pkg::KIND_W-1:0] kind;
    logic [pmc_pkg::RAND_W-1:0] ra;
    logic [pmc_pkg::RAND_W-1:0] rb;
  } carve_req_t;

  typedef struct packed {
    logic [pmc_pkg::COORD_W-1:0] cell_row;
    logic [pmc_pkg::COORD_W-1:0] cell_col;
    logic [pmc_pkg::COORD_W-1:0] link_row;
    logic [pmc_pkg::COORD_W-1:0] link_col;
    logic [pmc_pkg::DIR_W-1:0]   link_dir;
    logic                        carved;
    logic                        done_res;
  } carve_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pmc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [pmc_pkg::CFG_W-1:0] cfg_data_i = '0;

  pmc_in_if  in_if ();
  pmc_out_if out_if ();

  prim_maze_carver DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  carve_req_t pending_q[$];
  carve_res_t carve_q[$];
  logic [pmc_pkg::FLAG_W-1:0] maze_flags[NCELL];
  int unsigned frontier_q[$];
  logic [pmc_pkg::CFG_W-1:0] rows_reg = pmc_pkg::RESET_ROWS;
  logic [pmc_pkg::CFG_W-1:0] cols_reg = pmc_pkg::RESET_COLS;
  int unsigned errors = 0;
  int unsigned n_accepted = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = '0;
    in_if.first_random = '0;
    in_if.second_random = '0;
    out_if.ready = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned rows_eff();
    if (rows_reg == 0) return 1;
    if (rows_reg > NROW) return NROW;
    return rows_reg;
  endfunction

  function automatic int unsigned cols_eff();
    if (cols_reg == 0) return 1;
    if (cols_reg > NCOL) return NCOL;
    return cols_reg;
  endfunction

  function automatic void list_cell(int r, int c);
    int unsigned idx;
    if (r < 0 || c < 0 || r >= int'(rows_eff()) || c >= int'(cols_eff())) return;
    idx = r * NCOL + c;
    if (maze_flags[idx][pmc_pkg::FLAG_FRONT_BIT]) return;
    maze_flags[idx][pmc_pkg::FLAG_FRONT_BIT] = 1'b1;
    if (frontier_q.size() < NCELL) frontier_q.insert(frontier_q.size(), idx);
  endfunction

  function automatic void join_maze(int r, int c);
    maze_flags[r * NCOL + c][pmc_pkg::FLAG_IN_BIT] = 1'b1;
    list_cell(r - 1, c);
    list_cell(r + 1, c);
    list_cell(r, c - 1);
    list_cell(r, c + 1);
  endfunction

  function automatic void carve_predict(carve_req_t req);
    carve_res_t res;
    int unsigned rows, cols, r, c, idx, pick, n, b, d;
    int unsigned nr[4], nc[4], nd[4];
    rows = rows_eff();
    cols = cols_eff();
    res = '0;
    n = 0;
    if (req.kind == pmc_pkg::KIND_START) begin
      foreach (maze_flags[i]) maze_flags[i] = '0;
      frontier_q.delete();
      r = req.ra % rows;
      c = req.rb % cols;
      join_maze(r, c);
      maze_flags[r * NCOL + c][pmc_pkg::FLAG_FRONT_BIT] = 1'b1;
      res.cell_row = r[pmc_pkg::COORD_W-1:0];
      res.cell_col = c[pmc_pkg::COORD_W-1:0];
    end else if (frontier_q.size() == 0) begin
      res.done_res = 1'b1;
    end else begin
      pick = req.ra % frontier_q.size();
      idx = frontier_q[pick] % NCELL;
      frontier_q.delete(pick);
      r = idx / NCOL;
      c = idx % NCOL;
      if (r > 0 && r - 1 < rows && c < cols &&
          maze_flags[idx - NCOL][pmc_pkg::FLAG_IN_BIT]) begin
        nr[n] = r - 1; nc[n] = c; nd[n] = 0; n++;
      end
      if (r + 1 < rows && c < cols && maze_flags[idx + NCOL][pmc_pkg::FLAG_IN_BIT]) begin
        nr[n] = r + 1; nc[n] = c; nd[n] = 1; n++;
      end
      if (c > 0 && r < rows && c - 1 < cols &&
          maze_flags[idx - 1][pmc_pkg::FLAG_IN_BIT]) begin
        nr[n] = r; nc[n] = c - 1; nd[n] = 2; n++;
      end
      if (c + 1 < cols && r < rows && maze_flags[idx + 1][pmc_pkg::FLAG_IN_BIT]) begin
        nr[n] = r; nc[n] = c + 1; nd[n] = 3; n++;
      end
      res.cell_row = r[pmc_pkg::COORD_W-1:0];
      res.cell_col = c[pmc_pkg::COORD_W-1:0];
      if (n > 0) begin
        b = req.rb % n;
        d = nd[b];
        maze_flags[idx][d] = 1'b1;
        maze_flags[nr[b] * NCOL + nc[b]][d ^ 1] = 1'b1;
        res.link_row = nr[b][pmc_pkg::COORD_W-1:0];
        res.link_col = nc[b][pmc_pkg::COORD_W-1:0];
        res.link_dir = d[pmc_pkg::DIR_W-1:0];
        res.carved = 1'b1;
      end
      join_maze(r, c);
    end
    carve_q.insert(carve_q.size(), res);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: accepted items go to the predictor.
  always @(posedge clk_i) begin
    bit fire;
    int unsigned idle_pct;
    fire = in_if.valid && in_if.ready;
    idle_pct = (n_accepted < 180) ? 25 : (n_accepted < 360) ? 77 : 0;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (fire) begin
        carve_predict({in_if.kind, in_if.first_random, in_if.second_random});
        n_accepted <= n_accepted + 1;
      end
      if (!in_if.valid || fire) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          carve_req_t req;
          req = pending_q.pop_front();
          in_if.kind <= req.kind;
          in_if.first_random <= req.ra;
          in_if.second_random <= req.rb;
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, mid run, while the sender still has items queued.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= 300 && pending_q.size() >= 4) begin
      hold_left <= HOLD_N;
      hold_done <= 1'b1;
    end
  end

  // Monitor: compare each result item with the oldest expectation.
  always @(posedge clk_i) begin
    int unsigned idle_pct;
    carve_res_t want;
    idle_pct = (n_accepted < 180) ? 77 : (n_accepted < 360) ? 25 : 0;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (carve_q.size() == 0) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          want = carve_q.pop_front();
          if (out_if.cell_row !== want.cell_row)
            report_mismatch("cell_row", out_if.cell_row, want.cell_row);
          if (out_if.cell_col !== want.cell_col)
            report_mismatch("cell_col", out_if.cell_col, want.cell_col);
          if (out_if.link_row !== want.link_row)
            report_mismatch("link_row", out_if.link_row, want.link_row);
          if (out_if.link_col !== want.link_col)
            report_mismatch("link_col", out_if.link_col, want.link_col);
          if (out_if.link_dir !== want.link_dir)
            report_mismatch("link_dir", out_if.link_dir, want.link_dir);
          if (out_if.carved !== want.carved)
            report_mismatch("carved", out_if.carved, want.carved);
          if (out_if.done_res !== want.done_res)
            report_mismatch("done_res", out_if.done_res, want.done_res);
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_q.size() != 0 || carve_q.size() != 0 || in_if.valid) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [pmc_pkg::CFG_IDX_W-1:0] idx,
                           logic [pmc_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == pmc_pkg::REG_GRID_ROWS) rows_reg = val;
    else rows_reg = rows_reg;
    if (idx == pmc_pkg::REG_GRID_COLS) cols_reg = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_item(logic [pmc_pkg::KIND_W-1:0] k, logic [pmc_pkg::RAND_W-1:0] a,
                           logic [pmc_pkg::RAND_W-1:0] b);
    carve_req_t req;
    req = '{kind: k, ra: a, rb: b};
    pending_q.insert(pending_q.size(), req);
  endtask

  initial begin
    int unsigned total;
    int unsigned nsteps;
    int unsigned sel;
    logic [pmc_pkg::CFG_W-1:0] rv, cv;
    total = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    push_item(pmc_pkg::KIND_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(pmc_pkg::KIND_START, 32'h0, 32'h0);
    push_item(pmc_pkg::KIND_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(pmc_pkg::KIND_STEP, 32'h0, 32'h0);
    repeat (4) push_item(pmc_pkg::KIND_STEP, $urandom, $urandom);
    push_item(pmc_pkg::KIND_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (3) push_item(pmc_pkg::KIND_STEP, $urandom, $urandom);
    wait_idle();
    write_reg(pmc_pkg::REG_GRID_ROWS, 6'd2);
    write_reg(pmc_pkg::REG_GRID_COLS, 6'd2);
    repeat (4) push_item(pmc_pkg::KIND_STEP, $urandom, $urandom);
    wait_idle();
    write_reg(pmc_pkg::REG_GRID_ROWS, 6'd0);
    write_reg(pmc_pkg::REG_GRID_COLS, 6'd63);
    push_item(pmc_pkg::KIND_START, $urandom, 32'hFFFF_FFFF);
    repeat (3) push_item(pmc_pkg::KIND_STEP, $urandom, $urandom);
    wait_idle();
    write_reg(pmc_pkg::REG_GRID_ROWS, 6'd1);
    write_reg(pmc_pkg::REG_GRID_COLS, 6'd1);
    push_item(pmc_pkg::KIND_START, $urandom, $urandom);
    repeat (2) push_item(pmc_pkg::KIND_STEP, $urandom, $urandom);
    wait_idle();
    write_reg(pmc_pkg::REG_GRID_ROWS, 6'd32);
    write_reg(pmc_pkg::REG_GRID_COLS, 6'd32);
    push_item(pmc_pkg::KIND_START, 32'd31, 32'd31);
    repeat (3) push_item(pmc_pkg::KIND_STEP, $urandom, $urandom);
    total = 28;

    while (total < 540) begin
      wait_idle();
      sel = $urandom_range(99);
      if (sel < 75) begin
        rv = 6'($urandom_range(8, 1));
        cv = 6'($urandom_range(8, 1));
      end else if (sel < 90) begin
        rv = 6'($urandom_range(63, 0));
        cv = 6'($urandom_range(63, 0));
      end else begin
        rv = ($urandom_range(1)) ? 6'd32 : 6'd1;
        cv = ($urandom_range(1)) ? 6'd32 : 6'd0;
      end
      write_reg(pmc_pkg::REG_GRID_ROWS, rv);
      write_reg(pmc_pkg::REG_GRID_COLS, cv);
      if ($urandom_range(99) >= 15) begin
        push_item(pmc_pkg::KIND_START, $urandom, $urandom);
        total++;
      end
      nsteps = rows_eff() * cols_eff() + $urandom_range(2);
      if (nsteps > 40) nsteps = 40;
      repeat (nsteps) begin
        if ($urandom_range(99) < 4) push_item(pmc_pkg::KIND_START, $urandom, $urandom);
        else push_item(pmc_pkg::KIND_STEP, $urandom, $urandom);
        total++;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
